// File: sv/fcw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the FAT32 cluster chain walker.
// No dependencies; every other file refers to it by scoped names.
package fcw_pkg;

   localparam int TABLE_DEPTH_DEF = 4096;
   localparam int MAX_CHAIN_DEF   = 64;

   localparam int ENTRY_W     = 32;
   localparam int CLUSTER_W   = 28;   // significant bits of a FAT32 entry
   localparam int LBA_W       = 32;
   localparam int SPC_W       = 8;
   localparam int INDEX_W     = 12;
   localparam int POS_W       = 6;

   localparam logic [CLUSTER_W-1:0] END_OF_CHAIN       = 28'hFFFFFF8;
   localparam logic [LBA_W-1:0]     FIRST_DATA_CLUSTER = 32'd2;
   localparam logic [SPC_W-1:0]     SPC_RESET          = 8'd1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_WALK  = 1'b1;

   localparam logic CSR_AREA_START          = 1'b0;
   localparam logic CSR_SECTORS_PER_CLUSTER = 1'b1;

   typedef enum logic [1:0] {
      OUT_OK           = 2'd0,
      OUT_WRITE_ACK    = 2'd1,
      OUT_OUT_OF_TABLE = 2'd2,
      OUT_TRUNCATED    = 2'd3
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_ACK,
      ST_OOR
   } state_type;

   typedef struct packed {
      logic                 load;
      logic [CLUSTER_W-1:0] cluster;
   } lba_req_type;

endpackage

// File: sv/fcw_table_ram.sv
`timescale 1ns / 1ps
// Allocation table: single-port-write, registered-read synchronous memory.
// Depends on fcw_pkg for the entry width.
module fcw_table_ram #(
   parameter int TABLE_DEPTH = fcw_pkg::TABLE_DEPTH_DEF,
   localparam int AW = $clog2(TABLE_DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [fcw_pkg::ENTRY_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [fcw_pkg::ENTRY_W-1:0] rd_data
);

   logic [fcw_pkg::ENTRY_W-1:0] mem [TABLE_DEPTH];
   logic [fcw_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/fcw_lba_unit.sv
`timescale 1ns / 1ps
// Cluster base LBA: registered (cluster - 2) * sectors_per_cluster, then add area start.
// Depends on fcw_pkg for widths and the lba request struct.
module fcw_lba_unit (
   input  logic                      clock,
   input  fcw_pkg::lba_req_type      lba_req,
   input  logic [fcw_pkg::LBA_W-1:0] area_start,
   input  logic [fcw_pkg::SPC_W-1:0] sectors_per_cluster,
   output logic [fcw_pkg::LBA_W-1:0] lba
);

   logic [fcw_pkg::LBA_W-1:0] diff;
   logic [fcw_pkg::LBA_W-1:0] prod_in;
   logic [fcw_pkg::LBA_W-1:0] prod_ff;

   // offset wraps modulo 2^32, so clusters 0 and 1 land below the area start
   always_comb begin
      diff = {{(fcw_pkg::LBA_W - fcw_pkg::CLUSTER_W){1'b0}}, lba_req.cluster}
             - fcw_pkg::FIRST_DATA_CLUSTER;
      prod_in = diff * {{(fcw_pkg::LBA_W - fcw_pkg::SPC_W){1'b0}}, sectors_per_cluster};
   end

   always_ff @(posedge clock) begin
      if (lba_req.load) begin
         prod_ff <= prod_in;
      end
   end

   assign lba = area_start + prod_ff;

endmodule

// File: sv/fcw_walker.sv
`timescale 1ns / 1ps
// Chain walk sequencer: accepts items, reads the table once per cluster, drives the result beat.
// Depends on fcw_pkg; drives fcw_table_ram and fcw_lba_unit through its ports.
module fcw_walker #(
   parameter int TABLE_DEPTH = fcw_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_CHAIN   = fcw_pkg::MAX_CHAIN_DEF,
   localparam int AW = $clog2(TABLE_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   input  logic [fcw_pkg::INDEX_W-1:0]   req_cluster_index,
   input  logic [fcw_pkg::ENTRY_W-1:0]   req_entry_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fcw_pkg::INDEX_W-1:0]   rsp_cluster_number,
   output logic [fcw_pkg::LBA_W-1:0]     rsp_sector_lba,
   output logic [fcw_pkg::POS_W-1:0]     rsp_chain_position,
   output logic                          rsp_last_of_run,
   output logic [1:0]                    rsp_outcome,
   output logic                          ram_wr_en,
   output logic [AW-1:0]                 ram_wr_addr,
   output logic [fcw_pkg::ENTRY_W-1:0]   ram_wr_data,
   output logic                          ram_rd_en,
   output logic [AW-1:0]                 ram_rd_addr,
   input  logic [fcw_pkg::ENTRY_W-1:0]   ram_rd_data,
   output fcw_pkg::lba_req_type          lba_req,
   input  logic [fcw_pkg::LBA_W-1:0]     lba
);

   localparam logic [fcw_pkg::CLUSTER_W-1:0] DEPTH_C   = fcw_pkg::CLUSTER_W'(TABLE_DEPTH);
   localparam logic [fcw_pkg::POS_W-1:0]     FINAL_POS = fcw_pkg::POS_W'(MAX_CHAIN - 1);

   fcw_pkg::state_type state_ff, state_in;

   logic [fcw_pkg::CLUSTER_W-1:0] idx_ff, idx_in;
   logic [fcw_pkg::POS_W-1:0]     pos_ff, pos_in;
   fcw_pkg::outcome_type          ack_code_ff, ack_code_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fcw_pkg::INDEX_W-1:0]   rsp_cluster_ff;
   logic [fcw_pkg::LBA_W-1:0]     rsp_lba_ff;
   logic [fcw_pkg::POS_W-1:0]     rsp_pos_ff;
   logic                          rsp_last_ff;
   fcw_pkg::outcome_type          rsp_outcome_ff;

   logic                          accept;
   logic                          slot_free;
   logic [fcw_pkg::CLUSTER_W-1:0] req_idx_ext;
   logic                          req_in_range;
   logic                          idx_in_range;
   logic [fcw_pkg::CLUSTER_W-1:0] next_cluster;
   logic                          end_of_chain;
   logic                          final_pos;
   logic                          emit;
   logic                          emit_last;
   logic [fcw_pkg::LBA_W-1:0]     emit_lba;
   fcw_pkg::outcome_type          emit_outcome;

   always_comb begin
      slot_free    = !rsp_valid_ff || rsp_ready;
      req_idx_ext  = fcw_pkg::CLUSTER_W'(req_cluster_index);
      req_in_range = req_idx_ext < DEPTH_C;
      idx_in_range = idx_ff < DEPTH_C;
      next_cluster = ram_rd_data[fcw_pkg::CLUSTER_W-1:0];
      end_of_chain = next_cluster >= fcw_pkg::END_OF_CHAIN;
      final_pos    = pos_ff == FINAL_POS;
      accept       = req_valid && req_ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fcw_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_operation == fcw_pkg::OP_WRITE) ? fcw_pkg::ST_ACK
                                                                : fcw_pkg::ST_READ;
            end
         end
         fcw_pkg::ST_READ: begin
            state_in = idx_in_range ? fcw_pkg::ST_EVAL : fcw_pkg::ST_OOR;
         end
         fcw_pkg::ST_EVAL: begin
            if (slot_free) begin
               state_in = (end_of_chain || final_pos) ? fcw_pkg::ST_IDLE : fcw_pkg::ST_READ;
            end
         end
         fcw_pkg::ST_ACK, fcw_pkg::ST_OOR: begin
            if (slot_free) begin
               state_in = fcw_pkg::ST_IDLE;
            end
         end
         default: state_in = fcw_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      req_ready     = 1'b0;
      ram_rd_en     = 1'b0;
      lba_req.load  = 1'b0;
      emit          = 1'b0;
      emit_last     = 1'b1;
      emit_lba      = '0;
      emit_outcome  = fcw_pkg::OUT_OK;
      unique case (state_ff)
         fcw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         fcw_pkg::ST_READ: begin
            ram_rd_en    = idx_in_range;
            lba_req.load = idx_in_range;
         end
         fcw_pkg::ST_EVAL: begin
            emit      = slot_free;
            emit_last = end_of_chain || final_pos;
            emit_lba  = lba;
            if (!end_of_chain && final_pos) begin
               emit_outcome = fcw_pkg::OUT_TRUNCATED;
            end
         end
         fcw_pkg::ST_ACK: begin
            emit         = slot_free;
            emit_outcome = ack_code_ff;
         end
         fcw_pkg::ST_OOR: begin
            emit         = slot_free;
            emit_outcome = fcw_pkg::OUT_OUT_OF_TABLE;
         end
         default: ;
      endcase
      lba_req.cluster = idx_ff;
      ram_rd_addr     = idx_ff[AW-1:0];
      ram_wr_en       = accept && (req_operation == fcw_pkg::OP_WRITE) && req_in_range;
      ram_wr_addr     = req_idx_ext[AW-1:0];
      ram_wr_data     = req_entry_value;
   end

   always_comb begin
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      ack_code_in = ack_code_ff;
      if (accept) begin
         idx_in      = req_idx_ext;
         pos_in      = '0;
         ack_code_in = req_in_range ? fcw_pkg::OUT_WRITE_ACK : fcw_pkg::OUT_OUT_OF_TABLE;
      end else if (state_ff == fcw_pkg::ST_EVAL && emit && !emit_last) begin
         // advance to the next link
         idx_in = next_cluster;
         pos_in = pos_ff + 1'b1;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      ack_code_ff <= ack_code_in;
      if (emit) begin
         rsp_cluster_ff <= idx_ff[fcw_pkg::INDEX_W-1:0];
         rsp_lba_ff     <= emit_lba;
         rsp_pos_ff     <= pos_ff;
         rsp_last_ff    <= emit_last;
         rsp_outcome_ff <= emit_outcome;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cluster_number = rsp_cluster_ff;
   assign rsp_sector_lba     = rsp_lba_ff;
   assign rsp_chain_position = rsp_pos_ff;
   assign rsp_last_of_run    = rsp_last_ff;
   assign rsp_outcome        = rsp_outcome_ff;

`ifndef SYNTHESIS
   a_eval_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fcw_pkg::ST_EVAL) |->
         ($past(state_ff) == fcw_pkg::ST_READ || $past(state_ff) == fcw_pkg::ST_EVAL))
      else $error("table result evaluated without a preceding read");

   a_mid_beat_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff != fcw_pkg::ST_IDLE))
      else $error("non-final beat while walker is idle");

   a_mid_beat_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_outcome_ff == fcw_pkg::OUT_OK))
      else $error("non-final beat carries an error outcome");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fcw_pkg::ST_EVAL || state_ff == fcw_pkg::ST_READ) |->
         (pos_ff <= FINAL_POS))
      else $error("chain position past the truncation limit");
`endif

endmodule

// File: sv/fat_cluster_chain_walker.sv
`timescale 1ns / 1ps
// Write item: entry stored at accept, acknowledge beat registered from the ACK state.
// Walk item: one table read per cluster; each cluster passes a table read state and an evaluate
// state, which holds while the result register is full; a walk visits at most MAX_CHAIN clusters
// and no new item is accepted until it ends; each read needs the last.
// Reset clears the walker state and the result valid flag; config resets to area start 0 and
// one sector per cluster. The table is not cleared: entries are undefined until written.
module fat_cluster_chain_walker #(
   parameter int TABLE_DEPTH = fcw_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_CHAIN   = fcw_pkg::MAX_CHAIN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [fcw_pkg::LBA_W-1:0]   csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_operation,
   input  logic [fcw_pkg::INDEX_W-1:0] req_cluster_index,
   input  logic [fcw_pkg::ENTRY_W-1:0] req_entry_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [fcw_pkg::INDEX_W-1:0] rsp_cluster_number,
   output logic [fcw_pkg::LBA_W-1:0]   rsp_sector_lba,
   output logic [fcw_pkg::POS_W-1:0]   rsp_chain_position,
   output logic                        rsp_last_of_run,
   output logic [1:0]                  rsp_outcome
);

   localparam int AW = $clog2(TABLE_DEPTH);

   logic [fcw_pkg::LBA_W-1:0] area_start_ff, area_start_in;
   logic [fcw_pkg::SPC_W-1:0] spc_ff, spc_in;

   logic                        ram_wr_en;
   logic [AW-1:0]               ram_wr_addr;
   logic [fcw_pkg::ENTRY_W-1:0] ram_wr_data;
   logic                        ram_rd_en;
   logic [AW-1:0]               ram_rd_addr;
   logic [fcw_pkg::ENTRY_W-1:0] ram_rd_data;
   fcw_pkg::lba_req_type        lba_req;
   logic [fcw_pkg::LBA_W-1:0]   lba;

   always_comb begin
      area_start_in = area_start_ff;
      spc_in        = spc_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            fcw_pkg::CSR_AREA_START:          area_start_in = csr_wdata;
            fcw_pkg::CSR_SECTORS_PER_CLUSTER: spc_in = csr_wdata[fcw_pkg::SPC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_start_ff <= '0;
         spc_ff        <= fcw_pkg::SPC_RESET;
      end else begin
         area_start_ff <= area_start_in;
         spc_ff        <= spc_in;
      end
   end

   fcw_table_ram #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fcw_lba_unit u_lba (
      .clock               (clock),
      .lba_req             (lba_req),
      .area_start          (area_start_ff),
      .sectors_per_cluster (spc_ff),
      .lba                 (lba)
   );

   fcw_walker #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_CHAIN   (MAX_CHAIN)
   ) u_walker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_cluster_index  (req_cluster_index),
      .req_entry_value    (req_entry_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cluster_number (rsp_cluster_number),
      .rsp_sector_lba     (rsp_sector_lba),
      .rsp_chain_position (rsp_chain_position),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_outcome        (rsp_outcome),
      .ram_wr_en          (ram_wr_en),
      .ram_wr_addr        (ram_wr_addr),
      .ram_wr_data        (ram_wr_data),
      .ram_rd_en          (ram_rd_en),
      .ram_rd_addr        (ram_rd_addr),
      .ram_rd_data        (ram_rd_data),
      .lba_req            (lba_req),
      .lba                (lba)
   );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Testbench for fat_cluster_chain_walker: loads allocation table entries, walks cluster
// chains under several data area settings and checks every result beat against a chain
// follower kept here. Depends on fcw_pkg and the walker RTL only.
module testbench;

   localparam int TABLE_DEPTH = fcw_pkg::TABLE_DEPTH_DEF;
   localparam int CHAIN_LIMIT = fcw_pkg::MAX_CHAIN_DEF;
   localparam int NUM_PHASES  = 5;
   localparam int RANDOM_PER_PHASE = 84;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int PRINT_CAP   = 40;

   typedef struct {
      logic                        op;
      logic [fcw_pkg::INDEX_W-1:0] index;
      logic [fcw_pkg::ENTRY_W-1:0] value;
   } fat_request_type;

   typedef struct packed {
      logic [fcw_pkg::INDEX_W-1:0] cluster;
      logic [fcw_pkg::LBA_W-1:0]   lba;
      logic [fcw_pkg::POS_W-1:0]   position;
      logic                        last;
      fcw_pkg::outcome_type        outcome;
   } cluster_visit_type;

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        csr_wr_en = 1'b0;
   logic                        csr_index = fcw_pkg::CSR_AREA_START;
   logic [fcw_pkg::LBA_W-1:0]   csr_wdata = '0;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_operation = fcw_pkg::OP_WRITE;
   logic [fcw_pkg::INDEX_W-1:0] req_cluster_index = '0;
   logic [fcw_pkg::ENTRY_W-1:0] req_entry_value = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [fcw_pkg::INDEX_W-1:0] rsp_cluster_number;
   logic [fcw_pkg::LBA_W-1:0]   rsp_sector_lba;
   logic [fcw_pkg::POS_W-1:0]   rsp_chain_position;
   logic                        rsp_last_of_run;
   logic [1:0]                  rsp_outcome;

   fat_cluster_chain_walker u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_cluster_index  (req_cluster_index),
      .req_entry_value    (req_entry_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cluster_number (rsp_cluster_number),
      .rsp_sector_lba     (rsp_sector_lba),
      .rsp_chain_position (rsp_chain_position),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_outcome        (rsp_outcome)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Stimulus plan: requests waiting for the driver, plus a shadow of the table as it will
   // stand once those requests are taken, so that no walk ever reads an unloaded entry.
   fat_request_type             fat_requests[$];
   logic [fcw_pkg::ENTRY_W-1:0] plan_table[TABLE_DEPTH];
   bit                          plan_loaded[TABLE_DEPTH];
   logic [fcw_pkg::INDEX_W-1:0] loaded_entries[$];
   int                          planned = 0;

   // Chain follower state, updated on register writes and accepted beats only.
   logic [fcw_pkg::ENTRY_W-1:0] fat_table[TABLE_DEPTH];
   logic [fcw_pkg::LBA_W-1:0]   area_start_lba = '0;
   logic [fcw_pkg::SPC_W-1:0]   cluster_sectors = fcw_pkg::SPC_RESET;
   cluster_visit_type           cluster_visits[$];

   int req_beats = 0;
   int req_issued = 0;
   int req_gap = 0;
   int req_calm = 0;
   int rsp_stall = 0;
   int rsp_calm = 0;
   int fail_count = 0;
   int printed = 0;
   int visits_checked = 0;
   int acks_seen = 0;
   int ends_seen = 0;
   int out_of_table_seen = 0;
   int truncations_seen = 0;
   int cycles = 0;
   fat_request_type req_item;

   // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
   function automatic int next_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   function automatic void plan_write(logic [fcw_pkg::INDEX_W-1:0] index,
                                      logic [fcw_pkg::ENTRY_W-1:0] value);
      fat_request_type item;
      item.op = fcw_pkg::OP_WRITE;
      item.index = index;
      item.value = value;
      fat_requests.push_back(item);
      plan_table[index] = value;
      if (!plan_loaded[index]) loaded_entries.push_back(index);
      plan_loaded[index] = 1'b1;
      planned++;
   endfunction

   // Queue a walk only if every entry it will read has been loaded.
   function automatic bit plan_walk(logic [fcw_pkg::INDEX_W-1:0] start);
      fat_request_type item;
      logic [fcw_pkg::CLUSTER_W-1:0] cur;
      logic [fcw_pkg::CLUSTER_W-1:0] nxt;
      cur = fcw_pkg::CLUSTER_W'(start);
      for (int pos = 0; pos < CHAIN_LIMIT; pos++) begin
         if (cur >= TABLE_DEPTH) break;
         if (!plan_loaded[cur]) return 1'b0;
         nxt = plan_table[cur][fcw_pkg::CLUSTER_W-1:0];
         if (nxt >= fcw_pkg::END_OF_CHAIN) break;
         cur = nxt;
      end
      item.op = fcw_pkg::OP_WALK;
      item.index = start;
      item.value = $urandom;
      fat_requests.push_back(item);
      planned++;
      return 1'b1;
   endfunction

   // Link random clusters into a chain, close it with an end mark, a pointer past the
   // table or a loop back, then walk it from its head.
   function automatic void build_chain();
      logic [fcw_pkg::INDEX_W-1:0] nodes[0:71];
      logic [fcw_pkg::CLUSTER_W-1:0] tail;
      int len;
      int pick;
      bit ok;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
      for (int k = 0; k < len; k++) nodes[k] = fcw_pkg::INDEX_W'($urandom);
      for (int k = 0; k < len - 1; k++)
         plan_write(nodes[k], {4'($urandom), fcw_pkg::CLUSTER_W'(nodes[k+1])});
      pick = $urandom_range(0, 99);
      if (pick < 70)
         tail = fcw_pkg::END_OF_CHAIN + fcw_pkg::CLUSTER_W'($urandom_range(0, 7));
      else if (pick < 85)
         tail = fcw_pkg::CLUSTER_W'($urandom_range(TABLE_DEPTH, 32'h0FFFFFF7));
      else
         tail = fcw_pkg::CLUSTER_W'(nodes[$urandom_range(0, len - 1)]);
      plan_write(nodes[len-1], {4'($urandom), tail});
      ok = plan_walk(nodes[0]);
   endfunction

   function automatic void random_walk();
      bit ok;
      ok = 1'b0;
      if ($urandom_range(0, 1) == 1) ok = plan_walk(fcw_pkg::INDEX_W'($urandom));
      for (int tries = 0; tries < 8 && !ok && loaded_entries.size() > 0; tries++)
         ok = plan_walk(loaded_entries[$urandom_range(0, loaded_entries.size() - 1)]);
   endfunction

   // Expected beats for one accepted request.
   function automatic void follow_chain(logic op, logic [fcw_pkg::INDEX_W-1:0] index,
                                        logic [fcw_pkg::ENTRY_W-1:0] value);
      cluster_visit_type visit;
      logic [fcw_pkg::CLUSTER_W-1:0] cur;
      logic [fcw_pkg::CLUSTER_W-1:0] nxt;
      // The index port cannot address past the table, so a write always lands.
      if (op == fcw_pkg::OP_WRITE) begin
         fat_table[index] = value;
         visit = '{index, '0, '0, 1'b1, fcw_pkg::OUT_WRITE_ACK};
         cluster_visits.push_back(visit);
         return;
      end
      cur = fcw_pkg::CLUSTER_W'(index);
      for (int pos = 0; pos < CHAIN_LIMIT; pos++) begin
         visit.cluster = cur[fcw_pkg::INDEX_W-1:0];
         visit.position = fcw_pkg::POS_W'(pos);
         if (cur >= TABLE_DEPTH) begin
            visit.lba = '0;
            visit.last = 1'b1;
            visit.outcome = fcw_pkg::OUT_OUT_OF_TABLE;
            cluster_visits.push_back(visit);
            return;
         end
         nxt = fat_table[cur][fcw_pkg::CLUSTER_W-1:0];
         visit.lba = area_start_lba + (fcw_pkg::LBA_W'(cur) - fcw_pkg::FIRST_DATA_CLUSTER) *
                     fcw_pkg::LBA_W'(cluster_sectors);
         visit.last = 1'b1;
         if (nxt >= fcw_pkg::END_OF_CHAIN) begin
            visit.outcome = fcw_pkg::OUT_OK;
            cluster_visits.push_back(visit);
            return;
         end
         if (pos == CHAIN_LIMIT - 1) begin
            visit.outcome = fcw_pkg::OUT_TRUNCATED;
            cluster_visits.push_back(visit);
            return;
         end
         visit.last = 1'b0;
         visit.outcome = fcw_pkg::OUT_OK;
         cluster_visits.push_back(visit);
         cur = nxt;
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         if (printed < PRINT_CAP) begin
            printed++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      end
   endfunction

   // Request driver: hold the beat until taken, then idle or present the next one.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_beats != req_issued) begin
      end else if (req_gap > 0) begin
         req_gap--;
         req_valid <= 1'b0;
      end else if (fat_requests.size() > 0) begin
         req_item = fat_requests.pop_front();
         req_operation <= req_item.op;
         req_cluster_index <= req_item.index;
         req_entry_value <= req_item.value;
         req_valid <= 1'b1;
         req_issued++;
         req_gap = next_gap(req_calm);
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall = next_gap(rsp_calm);
      end
   end

   // Monitor: track register writes, predict on request beats, check result beats.
   always @(posedge clock) begin
      cluster_visit_type want;
      if (!reset) begin
         if (csr_wr_en) begin
            if (csr_index == fcw_pkg::CSR_AREA_START) area_start_lba = csr_wdata;
            else cluster_sectors = csr_wdata[fcw_pkg::SPC_W-1:0];
         end
         if (req_valid && req_ready) begin
            req_beats++;
            follow_chain(req_operation, req_cluster_index, req_entry_value);
         end
         if (rsp_valid && rsp_ready) begin
            if (cluster_visits.size() == 0) begin
               fail_count++;
               if (printed < PRINT_CAP) begin
                  printed++;
                  $display("%0t ns: unexpected result beat, expected none, actual %h %h",
                           $time, rsp_cluster_number, rsp_sector_lba);
               end
            end else begin
               want = cluster_visits.pop_front();
               visits_checked++;
               check_field("cluster_number", 32'(want.cluster), 32'(rsp_cluster_number));
               check_field("sector_lba", want.lba, rsp_sector_lba);
               check_field("chain_position", 32'(want.position), 32'(rsp_chain_position));
               check_field("last_of_run", 32'(want.last), 32'(rsp_last_of_run));
               check_field("outcome", 32'(want.outcome), 32'(rsp_outcome));
               case (want.outcome)
                  fcw_pkg::OUT_WRITE_ACK:    acks_seen++;
                  fcw_pkg::OUT_OUT_OF_TABLE: out_of_table_seen++;
                  fcw_pkg::OUT_TRUNCATED:    truncations_seen++;
                  default: if (want.last) ends_seen++;
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t ns: run stopped at cycle limit, %0d beats still awaited",
                  $time, cluster_visits.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic wait_drained();
      do begin
         @(negedge clock);
         #1;
      end while (fat_requests.size() != 0 || req_valid || cluster_visits.size() != 0);
   endtask

   task automatic write_reg(logic index, logic [fcw_pkg::LBA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
   endtask

   initial begin
      logic [fcw_pkg::LBA_W-1:0] area_setting[NUM_PHASES];
      logic [fcw_pkg::SPC_W-1:0] spc_setting[NUM_PHASES];
      int phase_end;
      int r;
      bit ok;

      area_setting = '{32'h0, 32'hFFFFFFFF, $urandom, $urandom, 32'h80000000 | $urandom};
      spc_setting = '{8'd1, 8'd128, 8'd0, 8'd255, 8'($urandom_range(1, 128))};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         repeat (4) @(negedge clock);
         write_reg(fcw_pkg::CSR_AREA_START, area_setting[phase]);
         write_reg(fcw_pkg::CSR_SECTORS_PER_CLUSTER, {24'($urandom), spc_setting[phase]});
         @(negedge clock);
         csr_wr_en <= 1'b0;

         if (phase == 0) begin
            // Low clusters wrap below the data area; top entry ends on an all-ones value.
            plan_write(12'd0, 32'h00000001);
            plan_write(12'd1, 32'h00000FFF);
            plan_write(12'hFFF, 32'hFFFFFFFF);
            // Exact end mark, ignored top nibble, pointers just past and far past the table.
            plan_write(12'd2, 32'h0FFFFFF8);
            plan_write(12'd3, 32'hF0000004);
            plan_write(12'd4, 32'h0FFFFFF7);
            plan_write(12'd5, 32'h00001000);
            // Self loop runs into truncation.
            plan_write(12'd6, 32'h00000006);
            plan_write(12'd8, 32'h00000000);
            ok = plan_walk(12'd0);
            ok = plan_walk(12'd2);
            ok = plan_walk(12'd3);
            ok = plan_walk(12'd5);
            ok = plan_walk(12'd6);
            ok = plan_walk(12'd8);
            ok = plan_walk(12'hFFF);
         end else begin
            ok = plan_walk(12'd0);
            ok = plan_walk(12'd6);
         end

         phase_end = planned + RANDOM_PER_PHASE;
         while (planned < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 45) build_chain();
            else if (r < 70) plan_write(fcw_pkg::INDEX_W'($urandom), $urandom);
            else random_walk();
         end
         wait_drained();
      end

      repeat (2 * CHAIN_LIMIT + 8) @(negedge clock);
      $display("Sent %0d requests over %0d data area settings; checked %0d result beats.",
               req_beats, NUM_PHASES, visits_checked);
      $display("Walks closed by end mark %0d, out of table %0d, truncated %0d; writes %0d.",
               ends_seen, out_of_table_seen, truncations_seen, acks_seen);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
